// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a consequent in the same cycle as its antecedent
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// check that a condition never holds
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/cnc_pkg.sv =====
package cnc_pkg;

  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int ODAY_W   = 6;
  localparam int WDAY_W   = 3;
  localparam int HOUR_W   = 6;
  localparam int OHOUR_W  = 5;
  localparam int MIN_W    = 7;
  localparam int OMIN_W   = 6;
  localparam int ORDER_W  = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  typedef logic [YEAR_W-1:0]     year_t;
  typedef logic [MONTH_W-1:0]    month_t;
  typedef logic [DAY_W-1:0]      day_t;
  typedef logic [ODAY_W-1:0]     oday_t;
  typedef logic [WDAY_W-1:0]     wday_t;
  typedef logic [HOUR_W-1:0]     hour_t;
  typedef logic [OHOUR_W-1:0]    ohour_t;
  typedef logic [MIN_W-1:0]      min_t;
  typedef logic [OMIN_W-1:0]     omin_t;
  typedef logic [ORDER_W-1:0]    order_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam cfg_idx_t CFG_ALARM_YEAR   = 3'd0;
  localparam cfg_idx_t CFG_ALARM_MONTH  = 3'd1;
  localparam cfg_idx_t CFG_ALARM_DAY    = 3'd2;
  localparam cfg_idx_t CFG_ALARM_HOUR   = 3'd3;
  localparam cfg_idx_t CFG_ALARM_MINUTE = 3'd4;
  localparam cfg_idx_t CFG_ALARM_SECOND = 3'd5;

  localparam order_t ORD_EARLIER = 2'd0;
  localparam order_t ORD_EQUAL   = 2'd1;
  localparam order_t ORD_LATER   = 2'd2;

  localparam logic [6:0] SECS_PER_MIN  = 7'd60;
  localparam logic [7:0] MINS_PER_HOUR = 8'd60;
  localparam logic [6:0] HOURS_PER_DAY = 7'd24;
  localparam logic [4:0] MONTHS_PER_YEAR = 5'd12;
  localparam logic [2:0] DAYS_PER_WEEK = 3'd7;

  // floor(y / 25) = (y * RECIP_25) >> RECIP_SHIFT, exact for any 14-bit year
  localparam int RECIP_W     = 16;
  localparam int RECIP_SHIFT = 20;
  localparam logic [RECIP_W-1:0] RECIP_25 = 16'd41944;
  localparam int PROD_W = YEAR_W + RECIP_W;
  localparam int QUOT_W = 10;

  function automatic day_t month_days(input month_t month, input logic leap);
    day_t d;
    case (month)
      4'd2: d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
      default: d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/core/calendar_normalize_compare_top.sv =====
// Calendar carry normaliser with alarm ordering.
// Input channel: a time value (in_year .. in_second) is taken at a rising edge
// with start high and busy low. busy is always low: a transaction may enter
// in every cycle.
// Result channel: out_valid is high for exactly one cycle with the normalised
// time and out_order (0 earlier than the alarm, 1 equal, 2 later). The
// receiver cannot hold results off and the block never needs it to.
// Pipeline: a transaction accepted at a rising edge passes through five
// register stages (seconds carry with the year reciprocal multiply, minutes
// carry with the leap test, hours carry, day and month carry, ordering) before
// its result is presented. Throughput is one transaction per cycle.
// Configuration: cfg_we, cfg_index, cfg_data write one alarm register per
// cycle (0 year, 1 month, 2 day, 3 hour, 4 minute, 5 second); other indexes
// are dropped. Write only while no transaction is in flight.
// Reset (rst_n low, synchronous) empties the pipeline and sets the alarm to
// year 1, January 1st, 00:00:00.
module calendar_normalize_compare_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  cnc_pkg::year_t     in_year,
  input  cnc_pkg::month_t    in_month,
  input  cnc_pkg::day_t      in_day,
  input  cnc_pkg::wday_t     in_weekday,
  input  cnc_pkg::hour_t     in_hour,
  input  cnc_pkg::min_t      in_minute,
  input  cnc_pkg::min_t      in_second,
  output logic               out_valid,
  output cnc_pkg::year_t     out_year,
  output cnc_pkg::month_t    out_month,
  output cnc_pkg::oday_t     out_day,
  output cnc_pkg::wday_t     out_weekday,
  output cnc_pkg::ohour_t    out_hour,
  output cnc_pkg::omin_t     out_minute,
  output cnc_pkg::omin_t     out_second,
  output cnc_pkg::order_t    out_order,
  input  logic               cfg_we,
  input  cnc_pkg::cfg_idx_t  cfg_index,
  input  cnc_pkg::cfg_data_t cfg_data
);
  import cnc_pkg::*;

  `include "assert_macros.svh"

  year_t  alarm_year_r;
  month_t alarm_month_r;
  day_t   alarm_day_r;
  ohour_t alarm_hour_r;
  omin_t  alarm_minute_r;
  omin_t  alarm_second_r;

  logic   in_acc;

  logic [PROD_W-1:0] s1_prod;
  logic              s1_sec_ge;
  logic              s1_valid_r;
  year_t             s1_year_r;
  month_t            s1_month_r;
  day_t              s1_day_r;
  wday_t             s1_wday_r;
  hour_t             s1_hour_r;
  logic [7:0]        s1_min_r;
  omin_t             s1_sec_r;
  logic [QUOT_W-1:0] s1_quot_r;

  logic        s2_min_ge;
  logic [7:0]  s2_min_sub;
  year_t       s2_q25;
  logic        s2_leap;
  logic        s2_valid_r;
  year_t       s2_year_r;
  month_t      s2_month_r;
  day_t        s2_day_r;
  wday_t       s2_wday_r;
  logic [6:0]  s2_hour_r;
  omin_t       s2_min_r;
  omin_t       s2_sec_r;
  day_t        s2_mlen_r;

  logic        s3_hour_ge;
  logic [6:0]  s3_hour_sub;
  wday_t       s3_wday_inc;
  logic        s3_valid_r;
  year_t       s3_year_r;
  month_t      s3_month_r;
  oday_t       s3_day_r;
  wday_t       s3_wday_r;
  ohour_t      s3_hour_r;
  omin_t       s3_min_r;
  omin_t       s3_sec_r;
  day_t        s3_mlen_r;

  logic        s4_day_gt;
  logic [4:0]  s4_month_inc;
  logic        s4_month_gt;
  logic        s4_valid_r;
  year_t       s4_year_r;
  month_t      s4_month_r;
  oday_t       s4_day_r;
  wday_t       s4_wday_r;
  ohour_t      s4_hour_r;
  omin_t       s4_min_r;
  omin_t       s4_sec_r;

  order_t      order_nxt;

  assign busy   = 1'b0;
  assign in_acc = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alarm_year_r   <= year_t'(1);
      alarm_month_r  <= month_t'(1);
      alarm_day_r    <= day_t'(1);
      alarm_hour_r   <= '0;
      alarm_minute_r <= '0;
      alarm_second_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ALARM_YEAR:   alarm_year_r   <= cfg_data[YEAR_W-1:0];
        CFG_ALARM_MONTH:  alarm_month_r  <= cfg_data[MONTH_W-1:0];
        CFG_ALARM_DAY:    alarm_day_r    <= cfg_data[DAY_W-1:0];
        CFG_ALARM_HOUR:   alarm_hour_r   <= cfg_data[OHOUR_W-1:0];
        CFG_ALARM_MINUTE: alarm_minute_r <= cfg_data[OMIN_W-1:0];
        CFG_ALARM_SECOND: alarm_second_r <= cfg_data[OMIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
      out_valid  <= s4_valid_r;
    end
  end

  // stage 1: seconds carry, year reciprocal multiply
  assign s1_sec_ge = (in_second >= SECS_PER_MIN);
  assign s1_prod   = PROD_W'(in_year) * PROD_W'(RECIP_25);

  always_ff @(posedge clk) begin
    s1_year_r  <= in_year;
    s1_month_r <= in_month;
    s1_day_r   <= in_day;
    s1_wday_r  <= in_weekday;
    s1_hour_r  <= in_hour;
    s1_min_r   <= {1'b0, in_minute} + {7'd0, s1_sec_ge};
    s1_sec_r   <= s1_sec_ge ? OMIN_W'(in_second - SECS_PER_MIN) : in_second[OMIN_W-1:0];
    s1_quot_r  <= s1_prod[PROD_W-1 -: QUOT_W];
  end

  // stage 2: minutes carry, leap test, month length
  assign s2_min_ge  = (s1_min_r >= MINS_PER_HOUR);
  assign s2_min_sub = s1_min_r - MINS_PER_HOUR;
  assign s2_q25     = {s1_quot_r, 4'b0} + {1'b0, s1_quot_r, 3'b0} + {4'b0, s1_quot_r};
  assign s2_leap    = (s1_year_r[1:0] == 2'd0) &&
                      ((s2_q25 != s1_year_r) || (s1_year_r[3:0] == 4'd0));

  always_ff @(posedge clk) begin
    s2_year_r  <= s1_year_r;
    s2_month_r <= s1_month_r;
    s2_day_r   <= s1_day_r;
    s2_wday_r  <= s1_wday_r;
    s2_hour_r  <= {1'b0, s1_hour_r} + {6'd0, s2_min_ge};
    s2_min_r   <= s2_min_ge ? s2_min_sub[OMIN_W-1:0] : s1_min_r[OMIN_W-1:0];
    s2_sec_r   <= s1_sec_r;
    s2_mlen_r  <= month_days(s1_month_r, s2_leap);
  end

  // stage 3: hours carry into day and weekday
  assign s3_hour_ge  = (s2_hour_r >= HOURS_PER_DAY);
  assign s3_hour_sub = s2_hour_r - HOURS_PER_DAY;
  assign s3_wday_inc = s2_wday_r + 3'd1;

  always_ff @(posedge clk) begin
    s3_year_r  <= s2_year_r;
    s3_month_r <= s2_month_r;
    s3_day_r   <= {1'b0, s2_day_r} + {5'd0, s3_hour_ge};
    if (s3_hour_ge) begin
      s3_wday_r <= (s3_wday_inc == DAYS_PER_WEEK) ? 3'd0 : s3_wday_inc;
    end else begin
      s3_wday_r <= s2_wday_r;
    end
    s3_hour_r  <= s3_hour_ge ? s3_hour_sub[OHOUR_W-1:0] : s2_hour_r[OHOUR_W-1:0];
    s3_min_r   <= s2_min_r;
    s3_sec_r   <= s2_sec_r;
    s3_mlen_r  <= s2_mlen_r;
  end

  // stage 4: day into month, month into year
  assign s4_day_gt    = (s3_day_r > {1'b0, s3_mlen_r});
  assign s4_month_inc = {1'b0, s3_month_r} + {4'd0, s4_day_gt};
  assign s4_month_gt  = (s4_month_inc > MONTHS_PER_YEAR);

  always_ff @(posedge clk) begin
    s4_year_r  <= s3_year_r + {13'd0, s4_month_gt};
    s4_month_r <= s4_month_gt ? month_t'(1) : s4_month_inc[MONTH_W-1:0];
    s4_day_r   <= s4_day_gt ? oday_t'(1) : s3_day_r;
    s4_wday_r  <= s3_wday_r;
    s4_hour_r  <= s3_hour_r;
    s4_min_r   <= s3_min_r;
    s4_sec_r   <= s3_sec_r;
  end

  // stage 5: order against the alarm, most significant field first
  always_comb begin
    if (s4_year_r != alarm_year_r) begin
      order_nxt = (s4_year_r > alarm_year_r) ? ORD_LATER : ORD_EARLIER;
    end else if (s4_month_r != alarm_month_r) begin
      order_nxt = (s4_month_r > alarm_month_r) ? ORD_LATER : ORD_EARLIER;
    end else if (s4_day_r != {1'b0, alarm_day_r}) begin
      order_nxt = (s4_day_r > {1'b0, alarm_day_r}) ? ORD_LATER : ORD_EARLIER;
    end else if (s4_hour_r != alarm_hour_r) begin
      order_nxt = (s4_hour_r > alarm_hour_r) ? ORD_LATER : ORD_EARLIER;
    end else if (s4_min_r != alarm_minute_r) begin
      order_nxt = (s4_min_r > alarm_minute_r) ? ORD_LATER : ORD_EARLIER;
    end else if (s4_sec_r != alarm_second_r) begin
      order_nxt = (s4_sec_r > alarm_second_r) ? ORD_LATER : ORD_EARLIER;
    end else begin
      order_nxt = ORD_EQUAL;
    end
  end

  always_ff @(posedge clk) begin
    out_year    <= s4_year_r;
    out_month   <= s4_month_r;
    out_day     <= s4_day_r;
    out_weekday <= s4_wday_r;
    out_hour    <= s4_hour_r;
    out_minute  <= s4_min_r;
    out_second  <= s4_sec_r;
    out_order   <= order_nxt;
  end

  `ASSERT_NEVER(a_month_range, out_valid && (out_month > month_t'(MONTHS_PER_YEAR)))
  `ASSERT_IMP(a_equal_match, out_valid && (out_order == ORD_EQUAL),
              (out_year == $past(alarm_year_r)) && (out_second == $past(alarm_second_r)))
  `ASSERT_IMP(a_latency, out_valid, $past(s1_valid_r, 4))
  `ASSERT_NEVER(a_order_code, out_valid && (out_order != ORD_EARLIER) &&
                (out_order != ORD_EQUAL) && (out_order != ORD_LATER))

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import cnc_pkg::*;

  localparam cfg_idx_t CFG_SPARE_LO = 3'd6;
  localparam cfg_idx_t CFG_SPARE_HI = 3'd7;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 75;

  typedef struct packed {
    year_t  year;
    month_t month;
    day_t   day;
    wday_t  weekday;
    hour_t  hour;
    min_t   minute;
    min_t   second;
  } clock_in_t;

  typedef struct packed {
    year_t  year;
    month_t month;
    oday_t  day;
    wday_t  weekday;
    ohour_t hour;
    omin_t  minute;
    omin_t  second;
    order_t order;
  } clock_out_t;

  class alarm_scoreboard;
    year_t      a_year;
    month_t     a_month;
    day_t       a_day;
    ohour_t     a_hour;
    omin_t      a_minute;
    omin_t      a_second;
    clock_out_t pending_normalised[$];
    int         errors;
    int         accepted;
    int         checked;
    int         order_seen[3];

    function new();
      a_year = 1;
      a_month = 1;
      a_day = 1;
      a_hour = 0;
      a_minute = 0;
      a_second = 0;
      errors = 0;
      accepted = 0;
      checked = 0;
      order_seen = '{0, 0, 0};
    endfunction

    function void write_reg(cfg_idx_t idx, cfg_data_t data);
      case (idx)
        CFG_ALARM_YEAR:   a_year = year_t'(data);
        CFG_ALARM_MONTH:  a_month = month_t'(data);
        CFG_ALARM_DAY:    a_day = day_t'(data);
        CFG_ALARM_HOUR:   a_hour = ohour_t'(data);
        CFG_ALARM_MINUTE: a_minute = omin_t'(data);
        CFG_ALARM_SECOND: a_second = omin_t'(data);
        default: ;
      endcase
    endfunction

    function int unsigned month_length(month_t m, year_t y);
      int unsigned yr;
      bit leap;
      yr = 32'(y);
      leap = ((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0;
      case (m)
        4'd2: return leap ? 29 : 28;
        4'd4, 4'd6, 4'd9, 4'd11: return 30;
        default: return 31;
      endcase
    endfunction

    function order_t rank(logic [13:0] a, logic [13:0] b);
      if (a > b) return ORD_LATER;
      if (a < b) return ORD_EARLIER;
      return ORD_EQUAL;
    endfunction

    function clock_out_t normalise(clock_in_t t);
      clock_out_t  r;
      int unsigned yr, mo, dy, wd, hr, mi, se, mlen;
      yr = 32'(t.year);
      mo = 32'(t.month);
      dy = 32'(t.day);
      wd = 32'(t.weekday);
      hr = 32'(t.hour);
      mi = 32'(t.minute);
      se = 32'(t.second);
      mlen = month_length(t.month, t.year);
      if (se >= 60) begin
        se -= 60;
        mi++;
      end
      if (mi >= 60) begin
        mi -= 60;
        hr++;
      end
      if (hr >= 24) begin
        hr -= 24;
        dy++;
        wd = (wd + 1) & 7;
        if (wd == 7) wd = 0;
      end
      if (dy > mlen) begin
        dy = 1;
        mo++;
      end
      if (mo > 12) begin
        mo = 1;
        yr++;
      end
      r.year = year_t'(yr);
      r.month = month_t'(mo);
      r.day = oday_t'(dy);
      r.weekday = wday_t'(wd);
      r.hour = ohour_t'(hr);
      r.minute = omin_t'(mi);
      r.second = omin_t'(se);
      r.order = rank(r.year, a_year);
      if (r.order == ORD_EQUAL) r.order = rank(14'(r.month), 14'(a_month));
      if (r.order == ORD_EQUAL) r.order = rank(14'(r.day), 14'(a_day));
      if (r.order == ORD_EQUAL) r.order = rank(14'(r.hour), 14'(a_hour));
      if (r.order == ORD_EQUAL) r.order = rank(14'(r.minute), 14'(a_minute));
      if (r.order == ORD_EQUAL) r.order = rank(14'(r.second), 14'(a_second));
      return r;
    endfunction

    function void note_input(clock_in_t t);
      pending_normalised.push_back(normalise(t));
      accepted++;
    endfunction

    function void match_field(string name, logic [13:0] want, logic [13:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(clock_out_t got);
      clock_out_t want;
      if (pending_normalised.size() == 0) begin
        $error("result with no transaction waiting");
        errors++;
        return;
      end
      want = pending_normalised.pop_front();
      checked++;
      if (want.order <= ORD_LATER) order_seen[want.order]++;
      match_field("out_year", want.year, got.year);
      match_field("out_month", 14'(want.month), 14'(got.month));
      match_field("out_day", 14'(want.day), 14'(got.day));
      match_field("out_weekday", 14'(want.weekday), 14'(got.weekday));
      match_field("out_hour", 14'(want.hour), 14'(got.hour));
      match_field("out_minute", 14'(want.minute), 14'(got.minute));
      match_field("out_second", 14'(want.second), 14'(got.second));
      match_field("out_order", 14'(want.order), 14'(got.order));
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  year_t     in_year;
  month_t    in_month;
  day_t      in_day;
  wday_t     in_weekday;
  hour_t     in_hour;
  min_t      in_minute;
  min_t      in_second;
  logic      out_valid;
  year_t     out_year;
  month_t    out_month;
  oday_t     out_day;
  wday_t     out_weekday;
  ohour_t    out_hour;
  omin_t     out_minute;
  omin_t     out_second;
  order_t    out_order;
  logic      cfg_we;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_data;

  alarm_scoreboard sb = new();
  int              alarm_settings = 1;

  calendar_normalize_compare_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_year(in_year), .in_month(in_month), .in_day(in_day),
    .in_weekday(in_weekday), .in_hour(in_hour), .in_minute(in_minute),
    .in_second(in_second),
    .out_valid(out_valid), .out_year(out_year), .out_month(out_month),
    .out_day(out_day), .out_weekday(out_weekday), .out_hour(out_hour),
    .out_minute(out_minute), .out_second(out_second), .out_order(out_order),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1)
      sb.check_result(clock_out_t'{out_year, out_month, out_day, out_weekday,
                                   out_hour, out_minute, out_second, out_order});
  end

  function automatic clock_in_t mk(int y, int mo, int d, int w, int h, int mi, int s);
    clock_in_t t;
    t.year = year_t'(y);
    t.month = month_t'(mo);
    t.day = day_t'(d);
    t.weekday = wday_t'(w);
    t.hour = hour_t'(h);
    t.minute = min_t'(mi);
    t.second = min_t'(s);
    return t;
  endfunction

  function automatic int carry_prone(int lo, int hi, int top);
    if ($urandom_range(0, 2) == 0) return $urandom_range(lo, hi);
    return $urandom_range(0, top);
  endfunction

  function automatic clock_in_t random_time();
    clock_in_t t;
    int        kind;
    int        yr;
    kind = $urandom_range(0, 19);
    if (kind < 2) begin
      t = clock_in_t'({$urandom, $urandom});
    end else if (kind < 4) begin
      t.year = sb.a_year;
      t.month = sb.a_month;
      t.day = sb.a_day;
      t.weekday = wday_t'($urandom_range(0, 6));
      t.hour = hour_t'(sb.a_hour);
      t.minute = min_t'(sb.a_minute);
      t.second = min_t'(sb.a_second + $urandom_range(0, 2));
      if ($urandom_range(0, 1) == 1 && sb.a_second != 0)
        t.second = min_t'(sb.a_second - 1);
    end else begin
      case ($urandom_range(0, 7))
        0: yr = 2000;
        1: yr = 1900;
        2: yr = 2024;
        3: yr = 2023;
        4: yr = 2100;
        5: yr = 9999;
        6: yr = 16383;
        default: yr = $urandom_range(1, 9999);
      endcase
      t.year = year_t'(yr);
      t.month = month_t'($urandom_range(1, 12));
      if ($urandom_range(0, 1) == 1)
        t.day = day_t'(sb.month_length(t.month, t.year));
      else
        t.day = day_t'($urandom_range(1, 31));
      t.weekday = wday_t'($urandom_range(0, 6));
      t.hour = hour_t'(carry_prone(22, 25, 47));
      t.minute = min_t'(carry_prone(58, 61, 119));
      t.second = min_t'(carry_prone(58, 61, 119));
    end
    return t;
  endfunction

  task automatic send_time(clock_in_t t);
    start <= 1'b1;
    in_year <= t.year;
    in_month <= t.month;
    in_day <= t.day;
    in_weekday <= t.weekday;
    in_hour <= t.hour;
    in_minute <= t.minute;
    in_second <= t.second;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_input(t);
  endtask

  task automatic hold_off(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending_normalised.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_data_t data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic set_alarm(int y, int mo, int d, int h, int mi, int s);
    write_reg(CFG_ALARM_YEAR, cfg_data_t'(y));
    write_reg(CFG_ALARM_MONTH, cfg_data_t'(mo));
    write_reg(CFG_ALARM_DAY, cfg_data_t'(d));
    write_reg(CFG_ALARM_HOUR, cfg_data_t'(h));
    write_reg(CFG_ALARM_MINUTE, cfg_data_t'(mi));
    write_reg(CFG_ALARM_SECOND, cfg_data_t'(s));
    write_reg(CFG_SPARE_LO, cfg_data_t'($urandom));
    write_reg(CFG_SPARE_HI, cfg_data_t'($urandom));
    cfg_we <= 1'b0;
    alarm_settings++;
  endtask

  initial begin
    clock_in_t directed[$];
    int        sent;
    int        burst;
    int        k;

    rst_n = 1'b0;
    start = 1'b0;
    in_year = '0;
    in_month = '0;
    in_day = '0;
    in_weekday = '0;
    in_hour = '0;
    in_minute = '0;
    in_second = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    directed = '{
      mk(1, 1, 1, 0, 0, 0, 0),
      mk(0, 12, 31, 6, 23, 59, 60),
      mk(0, 0, 0, 0, 0, 0, 0),
      mk(16383, 12, 31, 5, 47, 119, 119),
      mk(16383, 15, 31, 7, 63, 127, 127),
      mk(2000, 2, 29, 3, 24, 0, 0),
      mk(1900, 2, 28, 3, 24, 0, 0),
      mk(2024, 2, 28, 2, 23, 60, 0),
      mk(2023, 2, 28, 2, 23, 59, 60),
      mk(2100, 2, 28, 1, 24, 0, 0),
      mk(2024, 6, 10, 7, 12, 0, 0),
      mk(2024, 6, 10, 7, 23, 59, 61),
      mk(2024, 6, 10, 6, 24, 0, 0),
      mk(2024, 0, 31, 4, 24, 0, 0),
      mk(2024, 0, 15, 4, 10, 10, 10),
      mk(2024, 13, 5, 2, 10, 10, 10),
      mk(2024, 15, 31, 2, 24, 0, 0),
      mk(2024, 7, 0, 3, 5, 5, 5),
      mk(2024, 7, 0, 3, 24, 5, 5),
      mk(2024, 4, 31, 1, 8, 8, 8),
      mk(9999, 12, 31, 5, 23, 59, 60),
      mk(2024, 4, 30, 0, 23, 59, 59),
      mk(2024, 4, 30, 0, 22, 60, 0)
    };
    foreach (directed[i]) send_time(directed[i]);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: ;
        1: set_alarm(10000, 12, 31, 23, 59, 59);
        2: set_alarm(16383, 16383, 16383, 16383, 16383, 16383);
        3: set_alarm(2024, 2, 29, 12, 30, 30);
        4: set_alarm(1, 1, 1, 0, 0, 0);
        default: set_alarm(($urandom_range(0, 1) == 1) ? 2024 : $urandom_range(1, 10000),
                           $urandom_range(1, 12), $urandom_range(1, 31),
                           $urandom_range(0, 23), $urandom_range(0, 59),
                           $urandom_range(0, 59));
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        burst = $urandom_range(1, 24);
        for (k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
          send_time(random_time());
          sent++;
        end
        hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7));
      end
      drain();
    end

    repeat (12) @(posedge clk);
    $display("Normalised %0d time values under %0d alarm settings, %0d results checked",
             sb.accepted, alarm_settings, sb.checked);
    $display("Ordering against alarm: %0d earlier, %0d equal, %0d later",
             sb.order_seen[0], sb.order_seen[1], sb.order_seen[2]);
    if (sb.errors == 0 && sb.pending_normalised.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== calendar_normalize_compare_top.f =====
+incdir+rtl/core
rtl/core/cnc_pkg.sv
rtl/core/calendar_normalize_compare_top.sv
tb/testbench.sv
